// ----- rtl/etf_pkg.sv -----
package etf_pkg;

    localparam int FRAC_BITS     = 28;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int ITER_CAP      = 256;

    localparam longint C_RE_L = -(((64'sd7 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam longint C_IM_L = ((64'sd31 <<< FRAC_BITS) + 64'sd20) / 64'sd40;
    localparam logic signed [31:0] C_RE = 32'(C_RE_L);
    localparam logic signed [31:0] C_IM = 32'(C_IM_L);

    localparam logic [2:0] REG_REAL_MIN   = 3'd0;
    localparam logic [2:0] REG_REAL_MAX   = 3'd1;
    localparam logic [2:0] REG_IMAG_MIN   = 3'd2;
    localparam logic [2:0] REG_IMAG_MAX   = 3'd3;
    localparam logic [2:0] REG_WIDTH      = 3'd4;
    localparam logic [2:0] REG_HEIGHT     = 3'd5;
    localparam logic [2:0] REG_ESC_LIMIT  = 3'd6;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd7;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef logic signed [31:0] fix_t;
    typedef logic signed [32:0] mop_t;
    typedef logic signed [65:0] prod_t;

    function automatic fix_t sat32w(input prod_t v);
        fix_t r;
        if (v > 66'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -66'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic fix_t qmul(input prod_t p);
        return sat32w(p >>> FRAC_BITS);
    endfunction

    function automatic fix_t add_sat(input fix_t a, input fix_t b, input logic sub);
        logic signed [32:0] s;
        fix_t r;
        if (sub)
        begin
            s = $signed({a[31], a}) - $signed({b[31], b});
        end
        else
        begin
            s = $signed({a[31], a}) + $signed({b[31], b});
        end
        if (s[32] != s[31])
        begin
            r = s[32] ? 32'sh80000000 : 32'sh7fffffff;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/escape_time_fractal_pixel.sv -----
// Load request: written to the palette on accept, no result.
// Compute request, n = iterations (1..256): two bit-serial divisions set up
// the start point, then each of the n iterations runs on the single shared
// 33x33 multiplier. One request at a time. Reset restores the configuration
// defaults; palette contents are undefined until written.
module escape_time_fractal_pixel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [11:0] column,
    input  logic [11:0] row,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] x_out,
    output logic [12:0] y_out,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [8:0]  iterations,
    output logic        escaped
);
    import etf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVR, S_MULR, S_ZR, S_DIVI, S_MULI, S_ZI, S_ITER, S_RD, S_OUT
    } state_t;

    fix_t        real_min_reg, real_max_reg, imag_min_reg, imag_max_reg;
    logic [12:0] width_reg, height_reg;
    logic [30:0] esc_limit_reg;
    logic [8:0]  iter_limit_reg;

    logic        wr_en;
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_min_reg   <= -32'sd67108864;
            real_max_reg   <= 32'sd67108864;
            imag_min_reg   <= -32'sd67108864;
            imag_max_reg   <= 32'sd67108864;
            width_reg      <= 13'd640;
            height_reg     <= 13'd480;
            esc_limit_reg  <= 31'd1073741824;
            iter_limit_reg <= 9'd256;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_REAL_MIN:   real_min_reg   <= pwdata;
                REG_REAL_MAX:   real_max_reg   <= pwdata;
                REG_IMAG_MIN:   imag_min_reg   <= pwdata;
                REG_IMAG_MAX:   imag_max_reg   <= pwdata;
                REG_WIDTH:      width_reg      <= pwdata[12:0];
                REG_HEIGHT:     height_reg     <= pwdata[12:0];
                REG_ESC_LIMIT:  esc_limit_reg  <= pwdata[30:0];
                REG_ITER_LIMIT: iter_limit_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_REAL_MIN:   prdata = real_min_reg;
            REG_REAL_MAX:   prdata = real_max_reg;
            REG_IMAG_MIN:   prdata = imag_min_reg;
            REG_IMAG_MAX:   prdata = imag_max_reg;
            REG_WIDTH:      prdata = {19'd0, width_reg};
            REG_HEIGHT:     prdata = {19'd0, height_reg};
            REG_ESC_LIMIT:  prdata = {1'b0, esc_limit_reg};
            REG_ITER_LIMIT: prdata = {23'd0, iter_limit_reg};
            default:        prdata = '0;
        endcase
    end

    state_t      state_reg;
    logic [3:0]  cnt_reg;
    logic [11:0] col_reg, row_reg;
    fix_t        zr_reg, zi_reg, pr_reg, pi_reg, qr_reg, acc_reg;
    logic [63:0] sq_reg;
    logic [8:0]  iter_reg;
    logic        esc_reg;
    logic        out_valid_reg;
    logic [11:0] x_out_reg;
    logic [12:0] y_out_reg;
    logic [23:0] rgb_out_reg;
    logic [8:0]  iter_out_reg;
    logic        esc_out_reg;

    logic        accept;
    logic        out_free;
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = state_reg != S_IDLE;
    assign out_free = !out_valid_reg || !out_stall;

    logic signed [32:0] diff_r, diff_i;
    assign diff_r = $signed({real_max_reg[31], real_max_reg}) -
                    $signed({real_min_reg[31], real_min_reg});
    assign diff_i = $signed({imag_max_reg[31], imag_max_reg}) -
                    $signed({imag_min_reg[31], imag_min_reg});

    logic        div_start, div_busy, div_imag;
    logic [31:0] div_dividend, div_quotient;
    logic [12:0] div_divisor;
    logic [32:0] mag_r, mag_i;

    assign mag_r        = diff_r[32] ? 33'(-diff_r) : diff_r;
    assign mag_i        = diff_i[32] ? 33'(-diff_i) : diff_i;
    assign div_imag     = state_reg == S_ZR;
    assign div_start    = (accept && cmd == CMD_COMPUTE) || div_imag;
    assign div_dividend = div_imag ? mag_i[31:0] : mag_r[31:0];
    assign div_divisor  = div_imag ? ((height_reg == 13'd0) ? 13'd1 : height_reg)
                                   : ((width_reg == 13'd0) ? 13'd1 : width_reg);

    etf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    mop_t  step_s, mul_a, mul_b;
    prod_t prod;
    logic  step_neg;

    assign step_neg = (state_reg == S_MULI) ? diff_i[32] : diff_r[32];
    assign step_s   = step_neg ? -$signed({1'b0, div_quotient}) : $signed({1'b0, div_quotient});

    function automatic mop_t ext(input fix_t v);
        return $signed({v[31], v});
    endfunction

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MULR:
            begin
                mul_a = step_s;
                mul_b = $signed({21'd0, col_reg});
            end
            S_MULI:
            begin
                mul_a = step_s;
                mul_b = $signed({21'd0, row_reg});
            end
            S_ITER:
            begin
                case (cnt_reg)
                    4'd0:    begin mul_a = ext(C_RE);   mul_b = ext(zr_reg); end
                    4'd1:    begin mul_a = ext(C_IM);   mul_b = ext(zi_reg); end
                    4'd2:    begin mul_a = ext(C_RE);   mul_b = ext(zi_reg); end
                    4'd3:    begin mul_a = ext(C_IM);   mul_b = ext(zr_reg); end
                    4'd4:    begin mul_a = ext(pr_reg); mul_b = ext(zr_reg); end
                    4'd5:    begin mul_a = ext(pi_reg); mul_b = ext(zi_reg); end
                    4'd6:    begin mul_a = ext(pr_reg); mul_b = ext(zi_reg); end
                    4'd7:    begin mul_a = ext(pi_reg); mul_b = ext(zr_reg); end
                    4'd9:    begin mul_a = ext(zr_reg); mul_b = ext(zr_reg); end
                    4'd10:   begin mul_a = ext(zi_reg); mul_b = ext(zi_reg); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    etf_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    fix_t        qv;
    logic [63:0] mag_sq;
    logic [63:0] lim_sq;
    logic        esc_now;
    logic [8:0]  iter_next;
    logic [8:0]  lim_eff;
    prod_t       start_sum_r, start_sum_i;

    assign qv          = qmul(prod);
    assign mag_sq      = sq_reg + prod[63:0];
    assign lim_sq      = {33'd0, esc_limit_reg} << FRAC_BITS;
    assign esc_now     = mag_sq > lim_sq;
    assign iter_next   = iter_reg + 9'd1;
    assign lim_eff     = (iter_limit_reg == 9'd0) ? 9'd1 :
                         (iter_limit_reg > 9'(ITER_CAP)) ? 9'(ITER_CAP) : iter_limit_reg;
    assign start_sum_r = prod + $signed({{34{real_min_reg[31]}}, real_min_reg});
    assign start_sum_i = prod + $signed({{34{imag_min_reg[31]}}, imag_min_reg});

    logic [23:0] pal_rdata;

    etf_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_pal (
        .clk   (clk),
        .we    (accept && cmd == CMD_LOAD),
        .waddr (PAL_AW'(entry_index)),
        .wdata ({red_in, green_in, blue_in}),
        .raddr (iter_reg[PAL_AW-1:0]),
        .rdata (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            zr_reg        <= '0;
            zi_reg        <= '0;
            pr_reg        <= '0;
            pi_reg        <= '0;
            qr_reg        <= '0;
            acc_reg       <= '0;
            sq_reg        <= '0;
            iter_reg      <= '0;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            x_out_reg     <= '0;
            y_out_reg     <= '0;
            rgb_out_reg   <= '0;
            iter_out_reg  <= '0;
            esc_out_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && cmd == CMD_COMPUTE)
                    begin
                        col_reg   <= column;
                        row_reg   <= row;
                        state_reg <= S_DIVR;
                    end
                end
                S_DIVR:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_MULR;
                    end
                end
                S_MULR:
                begin
                    state_reg <= S_ZR;
                end
                S_ZR:
                begin
                    zr_reg    <= sat32w(start_sum_r);
                    state_reg <= S_DIVI;
                end
                S_DIVI:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_MULI;
                    end
                end
                S_MULI:
                begin
                    state_reg <= S_ZI;
                end
                S_ZI:
                begin
                    zi_reg    <= sat32w(start_sum_i);
                    iter_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    cnt_reg <= (cnt_reg == 4'd11) ? 4'd0 : cnt_reg + 4'd1;
                    case (cnt_reg)
                        4'd1, 4'd3, 4'd5, 4'd7: acc_reg <= qv;
                        4'd2:  pr_reg <= add_sat(acc_reg, qv, 1'b1);
                        4'd4:  pi_reg <= add_sat(acc_reg, qv, 1'b0);
                        4'd6:  qr_reg <= add_sat(acc_reg, qv, 1'b1);
                        4'd8:
                        begin
                            zr_reg <= add_sat(pr_reg, qr_reg, 1'b1);
                            zi_reg <= add_sat(pi_reg, add_sat(acc_reg, qv, 1'b0), 1'b1);
                        end
                        4'd10: sq_reg <= prod[63:0];
                        4'd11:
                        begin
                            iter_reg <= iter_next;
                            if (esc_now || iter_next >= lim_eff)
                            begin
                                esc_reg   <= esc_now && (iter_next < lim_eff);
                                state_reg <= S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
                S_RD:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        x_out_reg     <= col_reg;
                        y_out_reg     <= 13'(height_reg - {1'b0, row_reg});
                        rgb_out_reg   <= esc_reg ? pal_rdata : 24'd0;
                        iter_out_reg  <= iter_reg;
                        esc_out_reg   <= esc_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign x_out      = x_out_reg;
    assign y_out      = y_out_reg;
    assign red_out    = rgb_out_reg[23:16];
    assign green_out  = rgb_out_reg[15:8];
    assign blue_out   = rgb_out_reg[7:0];
    assign iterations = iter_out_reg;
    assign escaped    = esc_out_reg;

endmodule

// ----- rtl/etf_mul.sv -----
module etf_mul (
    input  logic           clk,
    input  etf_pkg::mop_t  a,
    input  etf_pkg::mop_t  b,
    output etf_pkg::prod_t p
);
    import etf_pkg::*;

    prod_t p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ----- rtl/etf_div.sv -----
module etf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [12:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [12:0] rem_reg;
    logic [12:0] div_reg;
    logic [31:0] quo_reg;
    logic [13:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
            rem_reg  <= '0;
            div_reg  <= divisor;
            quo_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? 13'(trial - {1'b0, div_reg}) : trial[12:0];
            quo_reg  <= {quo_reg[30:0], fits};
            cnt_reg  <= cnt_reg - 6'd1;
            busy_reg <= cnt_reg != 6'd1;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/etf_ram.sv -----
module etf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
